### design/pxc_pkg.sv
// shared types, codes and constants of the packet xor checksum codec
package pxc_pkg;

    // header layout
    localparam int HEADER_BYTES = 5;
    localparam int HDR_CODE     = 0;
    localparam int HDR_LEN_LO   = 1;
    localparam int HDR_LEN_HI   = 2;
    localparam int HDR_RANDOM   = 3;
    localparam int HDR_CHECK    = 4;

    // packet buffer, addressable part limited by the 12-bit position
    localparam int BUFFER_BYTES = 4096;
    localparam int POS_W        = 12;
    localparam int USABLE_BYTES = (BUFFER_BYTES < (1 << POS_W)) ? BUFFER_BYTES : (1 << POS_W);

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 13;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION   = 2'd0,
        CFG_PACKET_CODE = 2'd1,
        CFG_KEY_ONE     = 2'd2,
        CFG_KEY_TWO     = 2'd3
    } t_cfg_idx;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_PENDING      = 3'd0,
        ST_PASS         = 3'd1,
        ST_BAD_CODE     = 3'd2,
        ST_BAD_CHECKSUM = 3'd3,
        ST_TOO_SHORT    = 3'd4,
        ST_OVERFLOW     = 3'd5
    } t_status;

    // input beat
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] random_byte;
        logic              has_byte;
        logic              end_of_packet;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] value;
        logic              write_valid;
        t_status           status;
        logic              last_result;
    } t_out_item;

endpackage

### design/pxc_in_if.sv
// input channel of the codec: valid, ready and one packet byte beat
interface pxc_in_if;
    import pxc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/pxc_out_if.sv
// output channel of the codec: valid, ready and one buffer write beat
interface pxc_out_if;
    import pxc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/packet_xor_checksum_codec.sv
// packet xor checksum codec: encode/decode of a streamed packet into buffer writes
// Latency: a result beat is offered the cycle after its input beat is accepted.
// Throughput (output ready): one input beat per cycle if each beat gives at most
//   one result; encode end beats give up to six results, one per cycle, and hold
//   the input for that burst. Rate is set by the single output result register.
// Reset: synchronous, active low; clears configuration, packet state and output.
module packet_xor_checksum_codec (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pxc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pxc_pkg::BYTE_W-1:0]          i_cfg_data,
    pxc_in_if.sink                              i_in,
    pxc_out_if.source                           o_out
);
    import pxc_pkg::*;

    // burst steps: payload write first, then the five header writes
    localparam logic [2:0] STEP_PAY  = 3'd0;
    localparam logic [2:0] STEP_H0   = 3'd1;
    localparam logic [2:0] STEP_H1   = 3'd2;
    localparam logic [2:0] STEP_H2   = 3'd3;
    localparam logic [2:0] STEP_H3   = 3'd4;
    localparam logic [2:0] STEP_H4   = 3'd5;
    localparam int         POS_SUM_W = COUNT_W + 1;

    // configuration
    logic              r_direction;
    logic [BYTE_W-1:0] r_packet_code;
    logic [BYTE_W-1:0] r_key_one;
    logic [BYTE_W-1:0] r_key_two;

    // packet state
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [BYTE_W-1:0]  r_running_sum, n_running_sum;
    logic [BYTE_W-1:0]  r_packet_random, n_packet_random;
    logic [BYTE_W-1:0]  r_expected_checksum, n_expected_checksum;
    logic               r_code_matched, n_code_matched;
    logic               r_overflowed, n_overflowed;

    // result burst register
    logic               r_busy;
    logic [2:0]         r_step, n_start;
    logic               r_hdr, n_hdr;
    logic               n_any;
    logic [POS_W-1:0]   r_f_pos, n_f_pos;
    logic [BYTE_W-1:0]  r_f_val, n_f_val;
    logic               r_f_wv, n_f_wv;
    t_status            r_f_st, n_f_st;
    logic               r_f_last, n_f_last;
    logic [BYTE_W-1:0]  r_h_code, n_h_code;
    logic [COUNT_W-1:0] r_h_len, n_h_len;
    logic [BYTE_W-1:0]  r_h_keyed, n_h_keyed;
    logic [BYTE_W-1:0]  r_h_csum, n_h_csum;
    t_status            r_h_st, n_h_st;

    logic [2:0]         stop_step;
    logic               out_fire, burst_done, in_fire;

    // handshake
    assign stop_step  = r_hdr ? STEP_H4 : STEP_PAY;
    assign out_fire   = o_out.valid && o_out.ready;
    assign burst_done = out_fire && (r_step == stop_step);
    assign i_in.ready = !r_busy || burst_done;
    assign in_fire    = i_in.valid && i_in.ready;
    assign o_out.valid = r_busy;

    // per-beat processing against the packet state
    always_comb begin
        logic [BYTE_W-1:0]    key;
        logic [BYTE_W-1:0]    data;
        logic                 has;
        logic                 eop;
        logic                 active;
        logic                 wrote;
        logic [POS_SUM_W-1:0] enc_pos;
        logic [BYTE_W-1:0]    val;
        t_status              verdict;

        key  = r_key_one ^ r_key_two;
        data = i_in.data.data_byte;
        has  = i_in.data.has_byte;
        eop  = i_in.data.end_of_packet;
        active = has || eop;
        wrote = 1'b0;
        val = '0;
        verdict = ST_PASS;
        enc_pos = {1'b0, r_byte_count} + POS_SUM_W'(HEADER_BYTES);

        n_byte_count        = r_byte_count;
        n_running_sum       = r_running_sum;
        n_packet_random     = r_packet_random;
        n_expected_checksum = r_expected_checksum;
        n_code_matched      = r_code_matched;
        n_overflowed        = r_overflowed;

        n_any    = 1'b0;
        n_start  = STEP_PAY;
        n_hdr    = 1'b0;
        n_f_pos  = '0;
        n_f_val  = '0;
        n_f_wv   = 1'b0;
        n_f_st   = ST_PENDING;
        n_f_last = 1'b0;
        n_h_code = r_packet_code;
        n_h_len  = '0;
        n_h_keyed = '0;
        n_h_csum = '0;
        n_h_st   = ST_PASS;

        if (active && (r_direction == DIR_ENCODE)) begin
            // encode: sample random until first byte, key payload, header at end
            if (r_byte_count == '0) begin
                n_packet_random = i_in.data.random_byte;
            end
            if (has) begin
                if (enc_pos >= POS_SUM_W'(USABLE_BYTES)) begin
                    n_overflowed = 1'b1;
                end else begin
                    wrote         = 1'b1;
                    n_f_pos       = enc_pos[POS_W-1:0];
                    n_f_val       = data ^ n_packet_random;
                    n_f_wv        = 1'b1;
                    n_running_sum = r_running_sum + data;
                    n_byte_count  = r_byte_count + COUNT_W'(1);
                end
            end
            n_any   = wrote || eop;
            n_start = wrote ? STEP_PAY : STEP_H0;
            n_hdr   = eop;
            n_h_len   = n_byte_count;
            n_h_keyed = n_packet_random ^ key;
            n_h_csum  = n_running_sum ^ n_packet_random;
            n_h_st    = n_overflowed ? ST_OVERFLOW : ST_PASS;
        end else if (active) begin
            // decode: header fields then payload, verdict at end
            if (has) begin
                if (r_byte_count >= COUNT_W'(USABLE_BYTES)) begin
                    n_overflowed = 1'b1;
                end else begin
                    wrote = 1'b1;
                    if (r_byte_count == COUNT_W'(HDR_CODE)) begin
                        n_code_matched = (data == r_packet_code);
                        val = data;
                    end else if (r_byte_count == COUNT_W'(HDR_RANDOM)) begin
                        n_packet_random = data ^ key;
                        val = n_packet_random;
                    end else if (r_byte_count == COUNT_W'(HDR_CHECK)) begin
                        n_expected_checksum = data ^ r_packet_random;
                        val = n_expected_checksum;
                    end else if (r_byte_count >= COUNT_W'(HEADER_BYTES)) begin
                        val = data ^ r_packet_random;
                        n_running_sum = r_running_sum + val;
                    end else begin
                        val = data;
                    end
                    n_byte_count = r_byte_count + COUNT_W'(1);
                end
            end
            priority if (n_byte_count < COUNT_W'(HEADER_BYTES)) begin
                verdict = ST_TOO_SHORT;
            end else if (n_overflowed) begin
                verdict = ST_OVERFLOW;
            end else if (!n_code_matched) begin
                verdict = ST_BAD_CODE;
            end else if (n_running_sum != n_expected_checksum) begin
                verdict = ST_BAD_CHECKSUM;
            end else begin
                verdict = ST_PASS;
            end
            n_any    = wrote || eop;
            n_f_pos  = wrote ? r_byte_count[POS_W-1:0] : '0;
            n_f_val  = wrote ? val : '0;
            n_f_wv   = wrote;
            n_f_st   = eop ? verdict : ST_PENDING;
            n_f_last = eop;
        end

        // end of packet clears the packet state
        if (active && eop) begin
            n_byte_count        = '0;
            n_running_sum       = '0;
            n_packet_random     = '0;
            n_expected_checksum = '0;
            n_code_matched      = 1'b0;
            n_overflowed        = 1'b0;
        end
    end

    // output beat selection by burst step
    always_comb begin
        o_out.data.position    = r_f_pos;
        o_out.data.value       = r_f_val;
        o_out.data.write_valid = r_f_wv;
        o_out.data.status      = r_f_st;
        o_out.data.last_result = r_f_last;
        unique case (r_step)
            STEP_PAY: begin
            end
            STEP_H0: begin
                o_out.data = '{POS_W'(HDR_CODE), r_h_code, 1'b1, ST_PENDING, 1'b0};
            end
            STEP_H1: begin
                o_out.data = '{POS_W'(HDR_LEN_LO), r_h_len[BYTE_W-1:0], 1'b1,
                               ST_PENDING, 1'b0};
            end
            STEP_H2: begin
                o_out.data = '{POS_W'(HDR_LEN_HI),
                               BYTE_W'(r_h_len[COUNT_W-1:BYTE_W]), 1'b1,
                               ST_PENDING, 1'b0};
            end
            STEP_H3: begin
                o_out.data = '{POS_W'(HDR_RANDOM), r_h_keyed, 1'b1, ST_PENDING, 1'b0};
            end
            STEP_H4: begin
                o_out.data = '{POS_W'(HDR_CHECK), r_h_csum, 1'b1, r_h_st, 1'b1};
            end
            default: begin
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction         <= DIR_ENCODE;
            r_packet_code       <= '0;
            r_key_one           <= '0;
            r_key_two           <= '0;
            r_byte_count        <= '0;
            r_running_sum       <= '0;
            r_packet_random     <= '0;
            r_expected_checksum <= '0;
            r_code_matched      <= 1'b0;
            r_overflowed        <= 1'b0;
            r_busy              <= 1'b0;
            r_step              <= STEP_PAY;
            r_hdr               <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_DIRECTION:   r_direction   <= i_cfg_data[0];
                    CFG_PACKET_CODE: r_packet_code <= i_cfg_data;
                    CFG_KEY_ONE:     r_key_one     <= i_cfg_data;
                    CFG_KEY_TWO:     r_key_two     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // packet state on every accepted beat
            if (in_fire) begin
                r_byte_count        <= n_byte_count;
                r_running_sum       <= n_running_sum;
                r_packet_random     <= n_packet_random;
                r_expected_checksum <= n_expected_checksum;
                r_code_matched      <= n_code_matched;
                r_overflowed        <= n_overflowed;
            end
            // burst sequencing
            if (in_fire && n_any) begin
                r_busy <= 1'b1;
                r_step <= n_start;
                r_hdr  <= n_hdr;
            end else if (burst_done) begin
                r_busy <= 1'b0;
            end else if (out_fire) begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire && n_any) begin
            r_f_pos   <= n_f_pos;
            r_f_val   <= n_f_val;
            r_f_wv    <= n_f_wv;
            r_f_st    <= n_f_st;
            r_f_last  <= n_f_last;
            r_h_code  <= n_h_code;
            r_h_len   <= n_h_len;
            r_h_keyed <= n_h_keyed;
            r_h_csum  <= n_h_csum;
            r_h_st    <= n_h_st;
        end
    end

`ifndef SYNTHESIS
    // burst step never runs past its last beat
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= stop_step))
        else $error("burst step past its end");

    // a partly delivered burst keeps offering beats
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && (r_step != stop_step)) |=> (o_out.valid && (r_step == $past(r_step) + 3'd1)))
        else $error("header burst broken off");

    // the checksum header write closes the packet
    a_h4_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_step == STEP_H4)) |-> (o_out.data.last_result && r_hdr))
        else $error("checksum header write without packet end");

    // byte counter stays within the usable buffer
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= COUNT_W'(USABLE_BYTES))
        else $error("byte count beyond buffer");

    // an end beat leaves the packet state cleared
    a_eop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.data.end_of_packet) |=> ((r_byte_count == '0) && !r_overflowed))
        else $error("packet state not cleared at end");
`endif

endmodule

### dv/packet_xor_checksum_codec_tb.sv
// self-checking testbench of the packet xor checksum codec: random beats, predicted buffer writes
module packet_xor_checksum_codec_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pxc_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    // ways a decode packet can be spoiled on purpose
    typedef enum int {
        FLAW_NONE,
        FLAW_CODE,
        FLAW_SUM,
        FLAW_CUT
    } t_flaw;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we;
    t_cfg_idx          i_cfg_idx;
    logic [BYTE_W-1:0] i_cfg_data;

    pxc_in_if  in_if ();
    pxc_out_if out_if ();

    packet_xor_checksum_codec dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #1 i_clk = ~i_clk;

    // register copies seen by the predictor
    logic              cfg_direction = DIR_ENCODE;
    logic [BYTE_W-1:0] cfg_code      = '0;
    logic [BYTE_W-1:0] cfg_key_one   = '0;
    logic [BYTE_W-1:0] cfg_key_two   = '0;

    // predicted packet state
    logic [COUNT_W-1:0] byte_cnt   = '0;
    logic [BYTE_W-1:0]  pay_sum    = '0;
    logic [BYTE_W-1:0]  pkt_random = '0;
    logic [BYTE_W-1:0]  hdr_check  = '0;
    logic               code_ok    = 1'b0;
    logic               dropped    = 1'b0;

    t_in_item    byte_beats[$];
    t_out_item   buffer_writes_due[$];
    int unsigned real_beats = 0;
    int unsigned mismatches = 0;

    int unsigned in_gap   = 0;
    int unsigned out_wait = 0;
    bit          in_calm  = 1'b0;
    bit          out_calm = 1'b1;

    function automatic int unsigned draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic void clear_packet_state();
        byte_cnt   = '0;
        pay_sum    = '0;
        pkt_random = '0;
        hdr_check  = '0;
        code_ok    = 1'b0;
        dropped    = 1'b0;
    endfunction

    function automatic void expect_write(logic [POS_W-1:0] pos, logic [BYTE_W-1:0] val,
                                         logic wv, t_status st, logic last);
        t_out_item w;
        w.position    = pos;
        w.value       = val;
        w.write_valid = wv;
        w.status      = st;
        w.last_result = last;
        buffer_writes_due.push_back(w);
    endfunction

    // expected buffer writes of one accepted beat
    function automatic void predict_buffer_writes(t_in_item beat);
        logic [BYTE_W-1:0] key;
        logic [BYTE_W-1:0] val;
        logic [POS_W-1:0]  pos;
        logic              wrote;
        t_status           verdict;
        key   = cfg_key_one ^ cfg_key_two;
        val   = '0;
        pos   = byte_cnt[POS_W-1:0];
        wrote = 1'b0;
        if (!beat.has_byte && !beat.end_of_packet) return;

        if (cfg_direction == DIR_ENCODE) begin
            // random byte latched on every beat until the first payload byte lands
            if (byte_cnt == 0) pkt_random = beat.random_byte;
            if (beat.has_byte) begin
                if (HEADER_BYTES + int'(byte_cnt) >= USABLE_BYTES) begin
                    dropped = 1'b1;
                end else begin
                    expect_write(POS_W'(HEADER_BYTES + int'(byte_cnt)),
                                 beat.data_byte ^ pkt_random, 1'b1, ST_PENDING, 1'b0);
                    pay_sum  = pay_sum + beat.data_byte;
                    byte_cnt = byte_cnt + COUNT_W'(1);
                end
            end
            // header burst after the item's own payload write
            if (beat.end_of_packet) begin
                expect_write(POS_W'(HDR_CODE), cfg_code, 1'b1, ST_PENDING, 1'b0);
                expect_write(POS_W'(HDR_LEN_LO), byte_cnt[7:0], 1'b1, ST_PENDING, 1'b0);
                expect_write(POS_W'(HDR_LEN_HI), 8'(byte_cnt >> 8), 1'b1, ST_PENDING, 1'b0);
                expect_write(POS_W'(HDR_RANDOM), pkt_random ^ key, 1'b1, ST_PENDING, 1'b0);
                expect_write(POS_W'(HDR_CHECK), pay_sum ^ pkt_random, 1'b1,
                             dropped ? ST_OVERFLOW : ST_PASS, 1'b1);
                clear_packet_state();
            end
        end else begin
            // decode: header fields un-keyed, payload un-keyed and summed
            if (beat.has_byte) begin
                if (int'(byte_cnt) >= USABLE_BYTES) begin
                    dropped = 1'b1;
                end else begin
                    case (int'(byte_cnt))
                        HDR_CODE: begin
                            code_ok = (beat.data_byte == cfg_code);
                            val     = beat.data_byte;
                        end
                        HDR_LEN_LO, HDR_LEN_HI: begin
                            val = beat.data_byte;
                        end
                        HDR_RANDOM: begin
                            pkt_random = beat.data_byte ^ key;
                            val        = pkt_random;
                        end
                        HDR_CHECK: begin
                            hdr_check = beat.data_byte ^ pkt_random;
                            val       = hdr_check;
                        end
                        default: begin
                            val     = beat.data_byte ^ pkt_random;
                            pay_sum = pay_sum + val;
                        end
                    endcase
                    wrote    = 1'b1;
                    byte_cnt = byte_cnt + COUNT_W'(1);
                end
            end
            if (!beat.end_of_packet) begin
                if (wrote) expect_write(pos, val, 1'b1, ST_PENDING, 1'b0);
            end else begin
                if (int'(byte_cnt) < HEADER_BYTES) verdict = ST_TOO_SHORT;
                else if (dropped)                  verdict = ST_OVERFLOW;
                else if (!code_ok)                 verdict = ST_BAD_CODE;
                else if (pay_sum != hdr_check)     verdict = ST_BAD_CHECKSUM;
                else                               verdict = ST_PASS;
                if (wrote) expect_write(pos, val, 1'b1, verdict, 1'b1);
                else       expect_write('0, '0, 1'b0, verdict, 1'b1);
                clear_packet_state();
            end
        end
    endfunction

    function automatic string fmt_write(t_out_item w);
        return $sformatf("pos=%0d val=%02h wv=%0b st=%0d last=%0b",
                         w.position, w.value, w.write_valid, w.status, w.last_result);
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
    endfunction

    // compare one received write with the oldest expected one
    function automatic void check_buffer_write(t_out_item got);
        t_out_item want;
        if (buffer_writes_due.size() == 0) begin
            note_mismatch({"unexpected beat: ", fmt_write(got)});
            return;
        end
        want = buffer_writes_due.pop_front();
        if (got.position !== want.position || got.value !== want.value ||
            got.write_valid !== want.write_valid || got.status !== want.status ||
            got.last_result !== want.last_result)
            note_mismatch({"write differs: expected ", fmt_write(want),
                           " actual ", fmt_write(got)});
    endfunction

    // queue one beat, now and then preceded by an idle beat
    function automatic void add_beat(logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] rnd,
                                     logic has, logic eop);
        t_in_item b;
        if ($urandom_range(0, 11) == 0) begin
            b = '{data_byte: 8'($urandom), random_byte: 8'($urandom),
                  has_byte: 1'b0, end_of_packet: 1'b0};
            byte_beats.push_back(b);
        end
        b = '{data_byte: data, random_byte: rnd, has_byte: has, end_of_packet: eop};
        byte_beats.push_back(b);
        if (has || eop) real_beats++;
    endfunction

    // a packet's bytes, closed on the last byte or by a byte-less end beat
    function automatic void queue_packet(t_byte_q pkt_bytes, bit trailer);
        int unsigned n;
        n = pkt_bytes.size();
        for (int unsigned i = 0; i < n; i++)
            add_beat(pkt_bytes[i], 8'($urandom), 1'b1, (i == n - 1) && !trailer);
        if (n == 0 || trailer) add_beat(8'($urandom), 8'($urandom), 1'b0, 1'b1);
    endfunction

    function automatic void queue_encode_packet(int unsigned payload_len, bit trailer);
        t_byte_q pkt_bytes;
        for (int unsigned i = 0; i < payload_len; i++) pkt_bytes.push_back(8'($urandom));
        queue_packet(pkt_bytes, trailer);
    endfunction

    // well-formed encoded packet for the current code and key, optionally spoiled
    function automatic void queue_decode_packet(int unsigned payload_len, t_flaw flaw,
                                                bit trailer);
        t_byte_q           pkt_bytes;
        logic [BYTE_W-1:0] rnd;
        logic [BYTE_W-1:0] plain;
        logic [BYTE_W-1:0] sum;
        int unsigned       keep;
        rnd = 8'($urandom);
        sum = '0;
        pkt_bytes.push_back(flaw == FLAW_CODE ? cfg_code ^ 8'($urandom_range(1, 255))
                                              : cfg_code);
        pkt_bytes.push_back(8'(payload_len));
        pkt_bytes.push_back(8'(payload_len >> 8));
        pkt_bytes.push_back(rnd ^ cfg_key_one ^ cfg_key_two);
        pkt_bytes.push_back('0);
        for (int unsigned i = 0; i < payload_len; i++) begin
            plain = 8'($urandom);
            sum   = sum + plain;
            pkt_bytes.push_back(plain ^ rnd);
        end
        pkt_bytes[HDR_CHECK] = sum ^ rnd ^
                               (flaw == FLAW_SUM ? 8'($urandom_range(1, 255)) : 8'h00);
        if (flaw == FLAW_CUT) begin
            keep = $urandom_range(0, HEADER_BYTES - 1);
            while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
        end
        queue_packet(pkt_bytes, trailer);
    endfunction

    // wait until every queued beat is in and every expected write is out
    task automatic wait_idle();
        do @(posedge i_clk);
        while (byte_beats.size() != 0 || in_if.valid || buffer_writes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [BYTE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_DIRECTION:   cfg_direction = val[0];
            CFG_PACKET_CODE: cfg_code      = val;
            CFG_KEY_ONE:     cfg_key_one   = val;
            CFG_KEY_TWO:     cfg_key_two   = val;
        endcase
    endtask

    task automatic set_config(logic dir, logic [BYTE_W-1:0] code,
                              logic [BYTE_W-1:0] k1, logic [BYTE_W-1:0] k2);
        wait_idle();
        write_reg(CFG_DIRECTION, {7'd0, dir});
        write_reg(CFG_PACKET_CODE, code);
        write_reg(CFG_KEY_ONE, k1);
        write_reg(CFG_KEY_TWO, k2);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // input driver: one queued beat at a time, drawn gap after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_gap      <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_buffer_writes(in_if.data);
            end
            if (!in_if.valid || in_if.ready) begin
                if (in_gap != 0) begin
                    in_if.valid <= 1'b0;
                    in_gap      <= in_gap - 1;
                end else if (byte_beats.size() != 0) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= byte_beats.pop_front();
                    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
                    in_gap      <= draw_wait(in_calm);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: checks each write beat, then stalls a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            out_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                check_buffer_write(out_if.data);
                if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
                out_wait = draw_wait(out_calm);
            end
            if (out_wait != 0) begin
                out_if.ready <= 1'b0;
                out_wait = out_wait - 1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // stimulus sequence
    initial begin
        t_byte_q     no_bytes;
        int unsigned random_from;
        int unsigned phase_end;
        int unsigned r;
        t_flaw       flaw;

        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_DIRECTION;
        i_cfg_data   = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // encode: idle beat, empty packet, extreme bytes, byte-less end beat
        set_config(DIR_ENCODE, 8'hFF, 8'h00, 8'hFF);
        add_beat(8'hFF, 8'hFF, 1'b0, 1'b0);
        queue_packet(no_bytes, 1'b0);
        queue_packet({8'h00, 8'hFF}, 1'b0);
        queue_packet({8'h80}, 1'b1);

        // decode: pass with status-only end, bad code, too short, empty
        set_config(DIR_DECODE, 8'h00, 8'hFF, 8'h00);
        queue_decode_packet(1, FLAW_NONE, 1'b1);
        queue_decode_packet(0, FLAW_CODE, 1'b0);
        queue_decode_packet(2, FLAW_CUT, 1'b0);
        queue_packet(no_bytes, 1'b0);

        // random phases, each with its own register setting
        random_from = real_beats;
        for (int ph = 0; real_beats - random_from < 180; ph++) begin
            case (ph)
                0:       set_config(DIR_ENCODE, 8'h00, 8'h00, 8'h00);
                1:       set_config(DIR_DECODE, 8'hFF, 8'hFF, 8'hFF);
                default: set_config(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            phase_end = real_beats + 30;
            while (real_beats < phase_end) begin
                if (cfg_direction == DIR_ENCODE) begin
                    queue_encode_packet($urandom_range(0, 12), $urandom_range(0, 3) == 0);
                end else begin
                    r    = $urandom_range(0, 9);
                    flaw = (r < 7) ? FLAW_NONE : (r == 7) ? FLAW_CODE :
                           (r == 8) ? FLAW_SUM : FLAW_CUT;
                    queue_decode_packet($urandom_range(0, 12), flaw,
                                        $urandom_range(0, 3) == 0);
                end
            end
        end

        wait_idle();
        mismatches += buffer_writes_due.size();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
design/pxc_pkg.sv
design/pxc_in_if.sv
design/pxc_out_if.sv
design/packet_xor_checksum_codec.sv
dv/packet_xor_checksum_codec_tb.sv
